FILE: design/ssp_pkg.sv
// Package for the servo status packet parser: codes, phases and widths.
`default_nettype none

package ssp_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned TICK_W    = 16;
    localparam int unsigned RUN_W     = 2;

    localparam logic [BYTE_W-1:0] HDR_BYTE    = 8'hFF;
    localparam logic [BYTE_W-1:0] MAX_PAYLOAD = 8'd253;
    localparam logic [BYTE_W-1:0] MIN_LENGTH  = 8'd2;
    localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd1000;
    localparam logic [TICK_W-1:0] TICK_MAX    = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_TIMEOUT = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_ID      = 3'd2,
        PH_LENGTH  = 3'd3,
        PH_ERROR   = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CHECK   = 3'd6
    } phase_t;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

endpackage

`default_nettype wire

FILE: design/servo_status_packet_parser_unit.sv
// Servo bus status packet parser: header hunt, id/length check, payload stream, checksum.
//
// Usage: send a start transaction (cmd start) carrying the expected id and payload
// length, then one transaction per received byte (cmd byte) and one per timer tick
// (cmd tick). The unit answers with zero or one result transaction per input
// transaction: a payload byte (kind 0) for every payload byte of the reply, then one
// status transaction (kind 1, last 1) with ok, invalid response or timeout. Payload
// bytes leave before the checksum is checked, so drop them if the status is not ok.
// servo_error carries the device's error byte only with ok status. Bytes and ticks
// are ignored while no reception is armed; a start while busy silently abandons the
// reception in progress. Timing: one input register and one result register with a
// single pass of parser logic between them; unless out_stall holds the result register,
// a transaction is taken every cycle, its result moving from the input register to the
// result register; the throughput is one per clock, set by the parser state being updated
// in that single pass. in_stall rises only when the result register is held by out_stall
// and the input register is full. The timeout register (cfg_wdata, written with cfg_we)
// resets to 1000 ticks; the user must write it only while idle; the unit does not check.
`default_nettype none

module servo_status_packet_parser_unit
    import ssp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration
    input  wire logic              cfg_we,
    input  wire logic [TICK_W-1:0] cfg_wdata,
    // input channel
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        cmd,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire logic [BYTE_W-1:0] reply_id,
    input  wire logic [BYTE_W-1:0] reply_length,
    // result channel
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   kind,
    output logic [BYTE_W-1:0]      payload_byte,
    output logic [1:0]             status_code,
    output logic [BYTE_W-1:0]      servo_error,
    output logic                   last
);

    // timeout register
    logic [TICK_W-1:0] timeout_reg;

    // input register
    logic              in_vld_reg;
    logic [1:0]        cmd_reg;
    logic [BYTE_W-1:0] rx_byte_reg;
    logic [BYTE_W-1:0] exp_id_reg;
    logic [BYTE_W-1:0] exp_len_reg;

    // parser state
    phase_t            phase_reg,   phase_next;
    logic [RUN_W-1:0]  hdr_run_reg, hdr_run_next;
    logic [BYTE_W-1:0] want_id_reg, want_id_next;
    logic [BYTE_W-1:0] want_len_reg, want_len_next;
    logic [BYTE_W-1:0] got_len_reg, got_len_next;
    logic [BYTE_W-1:0] got_err_reg, got_err_next;
    logic [BYTE_W-1:0] done_reg,    done_next;
    logic [BYTE_W-1:0] sum_reg,     sum_next;
    logic [TICK_W-1:0] ticks_reg,   ticks_next;

    // result register
    logic              out_vld_reg;
    logic              kind_reg;
    logic [BYTE_W-1:0] pay_reg;
    logic [1:0]        status_reg;
    logic [BYTE_W-1:0] dev_err_reg;

    // single-pass results
    logic              emit;
    logic              emit_kind;
    logic [BYTE_W-1:0] emit_pay;
    logic [1:0]        emit_status;
    logic [BYTE_W-1:0] emit_dev_err;

    logic              advance;
    logic              in_accept;
    logic              work;

    // Result register frees up when empty or being drained this cycle.
    assign advance   = !out_vld_reg || !out_stall;
    assign in_stall  = in_vld_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign work      = in_vld_reg && advance;

    assign out_valid    = out_vld_reg;
    assign kind         = kind_reg;
    assign payload_byte = pay_reg;
    assign status_code  = status_reg;
    assign servo_error  = dev_err_reg;
    assign last         = kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            timeout_reg <= cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg     <= cmd;
            rx_byte_reg <= rx_byte;
            exp_id_reg  <= reply_id;
            exp_len_reg <= reply_length;
        end
    end

    // next-state logic
    always_comb
    begin
        logic [TICK_W-1:0] tick_inc;
        logic [BYTE_W-1:0] rx_id;
        logic [BYTE_W-1:0] done_inc;
        logic [RUN_W-1:0]  run_inc;

        tick_inc = (ticks_reg < TICK_MAX) ? (ticks_reg + TICK_W'(1)) : ticks_reg;
        rx_id    = sum_reg - got_len_reg;
        done_inc = done_reg + BYTE_W'(1);
        run_inc  = (rx_byte_reg == HDR_BYTE) ? (hdr_run_reg + RUN_W'(1)) : '0;

        phase_next    = phase_reg;
        hdr_run_next  = hdr_run_reg;
        want_id_next  = want_id_reg;
        want_len_next = want_len_reg;
        got_len_next  = got_len_reg;
        got_err_next  = got_err_reg;
        done_next     = done_reg;
        sum_next      = sum_reg;
        ticks_next    = ticks_reg;

        if (work)
        begin
            if (cmd_reg == CMD_START)
            begin
                want_id_next  = exp_id_reg;
                want_len_next = exp_len_reg;
                phase_next    = PH_HEADER;
                hdr_run_next  = '0;
                got_len_next  = '0;
                got_err_next  = '0;
                done_next     = '0;
                sum_next      = '0;
                ticks_next    = '0;
            end
            else if (phase_reg != PH_IDLE)
            begin
                if (cmd_reg == CMD_TICK)
                begin
                    ticks_next = tick_inc;
                    if (tick_inc >= timeout_reg)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                else if (cmd_reg == CMD_BYTE)
                begin
                    case (phase_reg)
                        PH_HEADER:
                        begin
                            hdr_run_next = run_inc;
                            if (run_inc >= RUN_W'(2))
                            begin
                                phase_next = PH_ID;
                            end
                        end
                        PH_ID:
                        begin
                            if (rx_byte_reg != HDR_BYTE)
                            begin
                                sum_next   = rx_byte_reg;
                                phase_next = PH_LENGTH;
                            end
                        end
                        PH_LENGTH:
                        begin
                            got_len_next = rx_byte_reg;
                            sum_next     = sum_reg + rx_byte_reg;
                            phase_next   = PH_ERROR;
                        end
                        PH_ERROR:
                        begin
                            got_err_next = rx_byte_reg;
                            sum_next     = sum_reg + rx_byte_reg;
                            done_next    = '0;
                            if (rx_id != want_id_reg || got_len_reg < MIN_LENGTH ||
                                (got_len_reg - MIN_LENGTH) != want_len_reg ||
                                want_len_reg > MAX_PAYLOAD)
                            begin
                                phase_next = PH_IDLE;
                            end
                            else if (want_len_reg == '0)
                            begin
                                phase_next = PH_CHECK;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                        PH_PAYLOAD:
                        begin
                            sum_next  = sum_reg + rx_byte_reg;
                            done_next = done_inc;
                            if (done_inc >= want_len_reg)
                            begin
                                phase_next = PH_CHECK;
                            end
                        end
                        PH_CHECK:
                        begin
                            phase_next = PH_IDLE;
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
        end
    end

    // result item logic
    always_comb
    begin
        logic [BYTE_W-1:0] rx_id;
        logic [TICK_W-1:0] tick_inc;

        rx_id    = sum_reg - got_len_reg;
        tick_inc = (ticks_reg < TICK_MAX) ? (ticks_reg + TICK_W'(1)) : ticks_reg;

        emit         = 1'b0;
        emit_kind    = KIND_STATUS;
        emit_pay     = '0;
        emit_status  = ST_OK;
        emit_dev_err = '0;

        if (in_vld_reg && cmd_reg != CMD_START && phase_reg != PH_IDLE)
        begin
            if (cmd_reg == CMD_TICK)
            begin
                if (tick_inc >= timeout_reg)
                begin
                    emit        = 1'b1;
                    emit_status = ST_TIMEOUT;
                end
            end
            else if (cmd_reg == CMD_BYTE)
            begin
                case (phase_reg)
                    PH_ERROR:
                    begin
                        if (rx_id != want_id_reg || got_len_reg < MIN_LENGTH ||
                            (got_len_reg - MIN_LENGTH) != want_len_reg ||
                            want_len_reg > MAX_PAYLOAD)
                        begin
                            emit        = 1'b1;
                            emit_status = ST_INVALID;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_PAYLOAD;
                        emit_pay  = rx_byte_reg;
                    end
                    PH_CHECK:
                    begin
                        emit = 1'b1;
                        if (~sum_reg == rx_byte_reg)
                        begin
                            emit_status  = ST_OK;
                            emit_dev_err = got_err_reg;
                        end
                        else
                        begin
                            emit_status = ST_INVALID;
                        end
                    end
                    default:
                    begin
                        emit = 1'b0;
                    end
                endcase
            end
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            hdr_run_reg  <= '0;
            want_id_reg  <= '0;
            want_len_reg <= '0;
            got_len_reg  <= '0;
            got_err_reg  <= '0;
            done_reg     <= '0;
            sum_reg      <= '0;
            ticks_reg    <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            hdr_run_reg  <= hdr_run_next;
            want_id_reg  <= want_id_next;
            want_len_reg <= want_len_next;
            got_len_reg  <= got_len_next;
            got_err_reg  <= got_err_next;
            done_reg     <= done_next;
            sum_reg      <= sum_next;
            ticks_reg    <= ticks_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= in_vld_reg && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (work && emit)
        begin
            kind_reg    <= emit_kind;
            pay_reg     <= emit_pay;
            status_reg  <= emit_status;
            dev_err_reg <= emit_dev_err;
        end
    end

    // A status transaction always closes the reception.
    a_status_ends_rx: assert property (@(posedge clk) disable iff (!rst_n)
        (work && emit && emit_kind == KIND_STATUS) |=> (phase_reg == PH_IDLE))
        else $error("parser still busy after a status transaction");

    // Error byte is reported only with ok status.
    a_dev_err_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && status_reg != ST_OK) |-> (dev_err_reg == '0))
        else $error("device error reported with non-ok status");

    // Stall only when a transaction is held in the input register.
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_vld_reg)
        else $error("input stalled with empty input register");

    // Payload transactions carry no status code.
    a_payload_no_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && kind_reg == KIND_PAYLOAD) |-> (status_reg == ST_OK))
        else $error("payload transaction with a status code");

endmodule

`default_nettype wire
